// ===== hdl/bdlp_pkg.sv =====
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int TIMER_BITS = 16;
  localparam int COUNT_BITS = 16;
  localparam int CFG_BITS = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int PHASE_BITS = 3;
  localparam int TOTAL_BITS = 16;
  localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT = 2'd2;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [CFG_BITS-1:0] REPEAT_RST = 16'd200;

  typedef enum logic [PHASE_BITS-1:0] {
    PH_IDLE = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_PRESSED = 3'd2,
    PH_LONG = 3'd3,
    PH_RELEASED = 3'd4
  } phase_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase_code;
    logic count_event;
    logic [TOTAL_BITS-1:0] press_total;
  } result_t;

endpackage

// ===== hdl/bdlp_fsm.sv =====
`timescale 1ns / 1ps

module bdlp_fsm (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bdlp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bdlp_pkg::CFG_BITS-1:0] cfg_wdata,
  input  logic                          step,
  input  logic                          pushed,
  output bdlp_pkg::result_t             res
);
  import bdlp_pkg::*;

  logic [CFG_BITS-1:0]   debounce_r;
  logic [CFG_BITS-1:0]   long_press_r;
  logic [CFG_BITS-1:0]   repeat_r;
  phase_t                phase_r;
  phase_t                phase_nxt;
  logic [TIMER_BITS-1:0] elapsed_r;
  logic [TIMER_BITS-1:0] elapsed_nxt;
  logic [COUNT_BITS-1:0] counter_r;
  logic [COUNT_BITS-1:0] counter_nxt;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic                  count_ev;
  logic                  deb_hit;
  logic                  long_hit;
  logic                  rep_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
      repeat_r <= REPEAT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_r <= cfg_wdata;
        CFG_LONG_PRESS: long_press_r <= cfg_wdata;
        CFG_REPEAT: repeat_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign elapsed_inc = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign deb_hit = CMP_BITS'(elapsed_inc) > CMP_BITS'(debounce_r);
  assign long_hit = CMP_BITS'(elapsed_inc) > CMP_BITS'(long_press_r);
  assign rep_hit = CMP_BITS'(elapsed_inc) > CMP_BITS'(repeat_r);

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_DEBOUNCE: begin
        if (!pushed) begin
          phase_nxt = PH_IDLE;
        end else if (deb_hit) begin
          phase_nxt = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (!pushed) begin
          phase_nxt = PH_RELEASED;
        end else if (long_hit) begin
          phase_nxt = PH_LONG;
        end
      end
      PH_LONG: begin
        if (rep_hit && !pushed) begin
          phase_nxt = PH_RELEASED;
        end
      end
      PH_RELEASED: phase_nxt = PH_IDLE;
      default: phase_nxt = pushed ? PH_DEBOUNCE : PH_IDLE;
    endcase
  end

  always_comb begin
    elapsed_nxt = elapsed_r;
    counter_nxt = counter_r;
    count_ev = 1'b0;
    case (phase_r)
      PH_DEBOUNCE: begin
        if (!pushed) begin
          elapsed_nxt = '0;
        end else if (deb_hit) begin
          elapsed_nxt = '0;
          counter_nxt = counter_r + 1'b1;
          count_ev = 1'b1;
        end else begin
          elapsed_nxt = elapsed_inc;
        end
      end
      PH_PRESSED: begin
        if (pushed) begin
          elapsed_nxt = long_hit ? '0 : elapsed_inc;
        end
      end
      PH_LONG: begin
        elapsed_nxt = elapsed_inc;
        if (rep_hit && pushed) begin
          elapsed_nxt = '0;
          counter_nxt = counter_r + 1'b1;
          count_ev = 1'b1;
        end
      end
      PH_RELEASED: elapsed_nxt = '0;
      default: begin
        if (pushed) begin
          elapsed_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      elapsed_r <= '0;
      counter_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      counter_r <= counter_nxt;
    end
  end

  assign res.phase_code = PHASE_BITS'(phase_nxt);
  assign res.count_event = count_ev;
  assign res.press_total = TOTAL_BITS'(counter_nxt);

endmodule

// ===== hdl/button_debounce_long_press.sv =====
`timescale 1ns / 1ps
// Each accepted result is registered in the output register (or the skid register if
// the output is stalled). Throughput: one transaction per cycle while in_stall is low.
// A two-entry output buffer keeps input accepted while one result waits to be taken.
// Reset (synchronous, rst_n low) returns to idle with timer and count cleared and the
// debounce, long-press and repeat registers at 50, 1000 and 200.

module button_debounce_long_press (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bdlp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bdlp_pkg::CFG_BITS-1:0]     cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_pushed,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bdlp_pkg::PHASE_BITS-1:0]   out_phase_code,
  output logic                              out_count_event,
  output logic [bdlp_pkg::TOTAL_BITS-1:0]   out_press_total
);
  import bdlp_pkg::*;

  logic    in_accept;
  logic    out_free;
  result_t res;
  result_t out_data_r;
  result_t skid_data_r;
  logic    out_valid_r;
  logic    skid_valid_r;

  assign in_stall = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  bdlp_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (in_accept),
    .pushed    (in_pushed),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= skid_valid_r || in_accept;
      skid_valid_r <= 1'b0;
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (!out_free && in_accept) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_phase_code = out_data_r.phase_code;
  assign out_count_event = out_data_r.count_event;
  assign out_press_total = out_data_r.press_total;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bdlp_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TICKS = 190;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0] data;
    logic pushed;
    logic checked;
    result_t want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b0, 1'b1, '{PH_IDLE, 1'b0, 16'd0}},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b1, 1'b1, '{PH_DEBOUNCE, 1'b0, 16'd0}},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b1, 1'b1, '{PH_DEBOUNCE, 1'b0, 16'd0}},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b0, 1'b1, '{PH_IDLE, 1'b0, 16'd0}},
    '{ROW_WRITE, CFG_UNUSED, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b1, 1'b1, '{PH_DEBOUNCE, 1'b0, 16'd0}},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b1, 1'b1, '{PH_DEBOUNCE, 1'b0, 16'd0}},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b0, 1'b1, '{PH_IDLE, 1'b0, 16'd0}},
    '{ROW_WRITE, CFG_DEBOUNCE, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_LONG_PRESS, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_REPEAT, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b1, 1'b1, '{PH_DEBOUNCE, 1'b0, 16'd0}},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b1, 1'b1, '{PH_PRESSED, 1'b1, 16'd1}},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b0, 1'b1, '{PH_RELEASED, 1'b0, 16'd1}},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b0, 1'b1, '{PH_IDLE, 1'b0, 16'd1}},
    '{ROW_WRITE, CFG_REPEAT, 16'd1, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_DEBOUNCE, 16'd0, 1'b0, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_DEBOUNCE;
  logic [CFG_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_pushed = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PHASE_BITS-1:0] out_phase_code;
  logic out_count_event;
  logic [TOTAL_BITS-1:0] out_press_total;

  phase_t btn_phase = PH_IDLE;
  logic [TIMER_BITS-1:0] hold_ticks = '0;
  logic [COUNT_BITS-1:0] press_count = '0;
  logic [CFG_BITS-1:0] debounce_limit = DEBOUNCE_RST;
  logic [CFG_BITS-1:0] long_press_limit = LONG_PRESS_RST;
  logic [CFG_BITS-1:0] repeat_limit = REPEAT_RST;

  result_t expected_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int in_burst_left = 0;
  int out_burst_left = 0;
  int out_pause_left = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;

  button_debounce_long_press dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pushed(in_pushed),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_phase_code(out_phase_code),
    .out_count_event(out_count_event),
    .out_press_total(out_press_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_pause();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [TIMER_BITS-1:0] timer_step(input logic [TIMER_BITS-1:0] t);
    return (t == TIMER_MAX) ? t : t + 1'b1;
  endfunction

  // One millisecond tick of the button qualifier.
  task automatic advance_button(input logic down, output result_t r);
    logic counted;
    counted = 1'b0;
    case (btn_phase)
      PH_DEBOUNCE: begin
        if (!down) begin
          btn_phase = PH_IDLE;
          hold_ticks = '0;
        end else begin
          hold_ticks = timer_step(hold_ticks);
          if (hold_ticks > debounce_limit) begin
            press_count = press_count + 1'b1;
            counted = 1'b1;
            btn_phase = PH_PRESSED;
            hold_ticks = '0;
          end
        end
      end
      PH_PRESSED: begin
        if (!down) begin
          btn_phase = PH_RELEASED;
        end else begin
          hold_ticks = timer_step(hold_ticks);
          if (hold_ticks > long_press_limit) begin
            btn_phase = PH_LONG;
            hold_ticks = '0;
          end
        end
      end
      PH_LONG: begin
        hold_ticks = timer_step(hold_ticks);
        if (hold_ticks > repeat_limit) begin
          if (down) begin
            press_count = press_count + 1'b1;
            counted = 1'b1;
            hold_ticks = '0;
          end else begin
            btn_phase = PH_RELEASED;
          end
        end
      end
      PH_RELEASED: begin
        btn_phase = PH_IDLE;
        hold_ticks = '0;
      end
      default: begin
        btn_phase = PH_IDLE;
        if (down) begin
          btn_phase = PH_DEBOUNCE;
          hold_ticks = '0;
        end
      end
    endcase
    r.phase_code = btn_phase;
    r.count_event = counted;
    r.press_total = press_count;
  endtask

  // Called at a falling edge; returns at a falling edge.
  task automatic send_tick(input logic p, input logic checked, input result_t want);
    result_t r;
    int gap;
    in_valid <= 1'b1;
    in_pushed <= p;
    do @(posedge clk); while (in_stall);
    advance_button(p, r);
    expected_results.push_back(checked ? want : r);
    @(negedge clk);
    if (in_burst_left == 0) begin
      in_quiet = ($urandom_range(0, 3) == 0);
      in_burst_left = $urandom_range(50, 400);
    end else begin
      in_burst_left--;
    end
    gap = (!in_quiet && $urandom_range(0, 3) == 0) ? pick_pause() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DEBOUNCE: debounce_limit = val;
      CFG_LONG_PRESS: long_press_limit = val;
      CFG_REPEAT: repeat_limit = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_timing(input logic [CFG_BITS-1:0] d, input logic [CFG_BITS-1:0] l,
                            input logic [CFG_BITS-1:0] rp);
    drain_results();
    write_reg(CFG_DEBOUNCE, d);
    write_reg(CFG_LONG_PRESS, l);
    write_reg(CFG_REPEAT, rp);
  endtask

  task automatic hold_and_release(input int hold, input int rel);
    repeat (hold) send_tick(1'b1, 1'b0, '0);
    repeat (rel) send_tick(1'b0, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    if (out_burst_left == 0) begin
      out_quiet = ($urandom_range(0, 3) == 0);
      out_burst_left = $urandom_range(50, 400);
    end else begin
      out_burst_left--;
    end
    if (out_pause_left != 0) begin
      out_pause_left--;
    end else if (!out_quiet && $urandom_range(0, 3) == 0) begin
      out_pause_left = pick_pause();
    end
    out_stall <= (out_pause_left != 0);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: phase_code %0d", out_phase_code);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_phase_code !== want.phase_code) begin
          $error("phase_code: expected %0d, got %0d", want.phase_code, out_phase_code);
          mismatches++;
        end
        if (out_count_event !== want.count_event) begin
          $error("count_event: expected %0d, got %0d", want.count_event, out_count_event);
          mismatches++;
        end
        if (out_press_total !== want.press_total) begin
          $error("press_total: expected %0d, got %0d", want.press_total, out_press_total);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int d;
    int l;
    int rp;
    int done;
    int hold;
    int rel;
    int n;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(DIRECTED[i].index, DIRECTED[i].data);
      end else begin
        send_tick(DIRECTED[i].pushed, DIRECTED[i].checked, DIRECTED[i].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      d = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 4);
      l = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
      rp = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
      set_timing(CFG_BITS'(d), CFG_BITS'(l), CFG_BITS'(rp));
      done = 0;
      while (done < PHASE_TICKS) begin
        if ($urandom_range(0, 4) != 0) begin
          hold = $urandom_range(1, d + l + 3 * (rp + 1) + 6);
          rel = ($urandom_range(0, 5) == 0) ? $urandom_range(0, rp + 1)
                                            : $urandom_range(rp + 2, rp + 6);
          hold_and_release(hold, rel);
          done += hold + rel;
        end else begin
          n = $urandom_range(1, 8);
          repeat (n) send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
          done += n;
        end
      end
      hold_and_release(0, rp + 3);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
